// File: hdl/bsmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsmt_pkg
// Shared sizes, codes and word layouts of the slot membership table.
// ----------------------------------------------------------------------------
package bsmt_pkg;

    localparam int BUCKETS = 256;
    localparam int SLOTS   = 8;
    localparam int MEMBERS = 1024;

    localparam int BKT_AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int MBR_AW = (MEMBERS > 1) ? $clog2(MEMBERS) : 1;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int CLR_N  = (BUCKETS > MEMBERS) ? BUCKETS : MEMBERS;
    localparam int CLR_W  = (CLR_N > 1) ? $clog2(CLR_N) : 1;

    localparam logic [1:0] CMD_PLACE  = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_COUNT  = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_UNPLACED = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [9:0]  member_id;
        logic [7:0]  bucket_id;
        logic [15:0] kind;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] slot_index;
        logic [3:0] match_count;
    } t_out_word;

    typedef struct packed {
        logic        valid;
        logic [9:0]  member_id;
        logic [15:0] kind;
    } t_slot;

    typedef t_slot [SLOTS-1:0] t_row;
    localparam int ROW_W = $bits(t_row);

    typedef struct packed {
        logic       valid;
        logic [7:0] bucket_id;
    } t_mb;
    localparam int MB_W = $bits(t_mb);

endpackage

// File: hdl/bucketed_slot_membership_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucketed_slot_membership_table_core
// Room/slot membership table: place, remove and same-kind count per word.
// ----------------------------------------------------------------------------
// Steps: every real command first reads the member table; place then visits
//   the old bucket row, if any, and the new one, count reads the member's row
//   and adds up the matches, remove writes back the old row. No new command is
//   taken until the result has gone into the output register.
// Reset: synchronous; afterwards a clearing pass over max(BUCKETS, MEMBERS)
//   addresses (1024 here) zeroes both RAMs while o_in_ready stays low.
// ----------------------------------------------------------------------------
module bucketed_slot_membership_table_core
    import bsmt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    // One-hot sequencer states.
    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,  // sweep both RAMs after reset
        S_IDLE  = 8'b0000_0010,  // wait for a command word
        S_MB    = 8'b0000_0100,  // member's bucket entry is on the read port
        S_OLD   = 8'b0000_1000,  // old bucket row on read port: take member out
        S_NEW   = 8'b0001_0000,  // target row on read port: first free slot
        S_CNT   = 8'b0010_0000,  // member's row on read port: compare kinds
        S_POP   = 8'b0100_0000,  // add up the match bits
        S_DONE  = 8'b1000_0000   // result held until the output register frees
    } t_state;

    t_state     r_state, n_state;
    logic [CLR_W-1:0] r_clr, n_clr;
    t_in_word   r_word, n_word;
    t_mb        r_mb, n_mb;
    t_row       r_mod_row, n_mod_row;
    logic       r_fwd, n_fwd;
    logic [SLOTS-1:0] r_match, n_match;
    t_out_word  r_res, n_res;
    logic       r_out_valid, n_out_valid;
    t_out_word  r_out_word, n_out_word;

    // RAM ports
    logic              mb_we;
    logic [MBR_AW-1:0] mb_waddr, mb_raddr;
    t_mb               mb_wdata, mb_rdata;
    logic              row_we;
    logic [BKT_AW-1:0] row_waddr, row_raddr;
    t_row              row_wdata, row_rdata;

    // Working signals
    logic       fin;
    t_out_word  res;
    logic       out_free;
    logic       old_in, new_in;
    logic       hit;
    logic       free_hit;
    logic [SLOT_W-1:0] free_idx;
    t_row       take_row;
    t_row       cur_row;
    t_row       put_row;
    logic [CNT_W-1:0] pop;

    // Member -> bucket table (valid + bucket id)
    bsmt_ram #(
        .WIDTH (MB_W),
        .DEPTH (MEMBERS)
    ) u_mb_ram (
        .i_clk   (i_clk),
        .i_we    (mb_we),
        .i_waddr (mb_waddr),
        .i_wdata (mb_wdata),
        .i_raddr (mb_raddr),
        .o_rdata (mb_rdata)
    );

    // One row per bucket, all slots side by side
    bsmt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign out_free    = !r_out_valid || i_out_ready;

    // Bucket range checks: out-of-range buckets hold nothing and have no room.
    assign old_in = (32'(mb_rdata.bucket_id) < BUCKETS);
    assign new_in = (32'(r_word.bucket_id) < BUCKETS);

    // Take the member out of the old row: first valid slot carrying its id.
    always_comb begin
        take_row = row_rdata;
        hit      = 1'b0;
        for (int s = 0; s < SLOTS; s++) begin
            if (!hit && row_rdata[s].valid &&
                row_rdata[s].member_id == r_word.member_id) begin
                take_row[s].valid     = 1'b0;
                take_row[s].member_id = '0;
                hit                   = 1'b1;
            end
        end
    end

    // Target row, forwarded from the take-out when both are the same bucket.
    assign cur_row = r_fwd ? r_mod_row : row_rdata;

    always_comb begin
        free_hit = 1'b0;
        free_idx = '0;
        put_row  = cur_row;
        for (int s = 0; s < SLOTS; s++) begin
            if (!free_hit && !cur_row[s].valid) begin
                free_hit              = 1'b1;
                free_idx              = SLOT_W'(s);
                put_row[s].valid      = 1'b1;
                put_row[s].member_id  = r_word.member_id;
                put_row[s].kind       = r_word.kind;
            end
        end
    end

    always_comb begin
        pop = '0;
        for (int s = 0; s < SLOTS; s++) begin
            pop = pop + CNT_W'(r_match[s]);
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_word      = r_word;
        n_mb        = r_mb;
        n_mod_row   = r_mod_row;
        n_fwd       = r_fwd;
        n_match     = r_match;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;

        mb_we     = 1'b0;
        mb_waddr  = MBR_AW'(r_word.member_id);
        mb_wdata  = '0;
        mb_raddr  = MBR_AW'(i_in_word.member_id);
        row_we    = 1'b0;
        row_waddr = BKT_AW'(r_mb.bucket_id);
        row_wdata = take_row;
        row_raddr = BKT_AW'(r_word.bucket_id);

        fin = 1'b0;
        res = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                mb_we     = (32'(r_clr) < MEMBERS);
                mb_waddr  = MBR_AW'(r_clr);
                row_we    = (32'(r_clr) < BUCKETS);
                row_waddr = BKT_AW'(r_clr);
                row_wdata = '0;
                if (32'(r_clr) == CLR_N - 1) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_word = i_in_word;
                    if (i_in_word.command == CMD_NOP) begin
                        fin = 1'b1;
                    end else if (32'(i_in_word.member_id) >= MEMBERS) begin
                        res.status = ST_UNPLACED;
                        fin        = 1'b1;
                    end else begin
                        n_state = S_MB;
                    end
                end
            end
            S_MB: begin
                n_mb = mb_rdata;
                unique case (r_word.command)
                    CMD_PLACE: begin
                        if (mb_rdata.valid && old_in) begin
                            row_raddr = BKT_AW'(mb_rdata.bucket_id);
                            n_state   = S_OLD;
                        end else if (new_in) begin
                            n_fwd   = 1'b0;
                            n_state = S_NEW;
                        end else begin
                            mb_we      = 1'b1;
                            res.status = ST_FULL;
                            fin        = 1'b1;
                        end
                    end
                    CMD_REMOVE: begin
                        if (!mb_rdata.valid) begin
                            res.status = ST_UNPLACED;
                            fin        = 1'b1;
                        end else if (old_in) begin
                            row_raddr = BKT_AW'(mb_rdata.bucket_id);
                            n_state   = S_OLD;
                        end else begin
                            mb_we = 1'b1;
                            fin   = 1'b1;
                        end
                    end
                    CMD_COUNT: begin
                        if (!mb_rdata.valid) begin
                            res.status = ST_UNPLACED;
                            fin        = 1'b1;
                        end else if (old_in) begin
                            row_raddr = BKT_AW'(mb_rdata.bucket_id);
                            n_state   = S_CNT;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    CMD_NOP: begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_OLD: begin
                // write back the row with the member taken out
                row_we    = 1'b1;
                n_mod_row = take_row;
                if (r_word.command == CMD_REMOVE) begin
                    mb_we = 1'b1;
                    fin   = 1'b1;
                end else if (new_in) begin
                    n_fwd   = (r_word.bucket_id == r_mb.bucket_id);
                    n_state = S_NEW;
                end else begin
                    mb_we      = 1'b1;
                    res.status = ST_FULL;
                    fin        = 1'b1;
                end
            end
            S_NEW: begin
                mb_we = 1'b1;
                fin   = 1'b1;
                if (free_hit) begin
                    row_we             = 1'b1;
                    row_waddr          = BKT_AW'(r_word.bucket_id);
                    row_wdata          = put_row;
                    mb_wdata.valid     = 1'b1;
                    mb_wdata.bucket_id = r_word.bucket_id;
                    res.slot_index     = 3'(free_idx);
                end else begin
                    res.status = ST_FULL;
                end
            end
            S_CNT: begin
                for (int s = 0; s < SLOTS; s++) begin
                    n_match[s] = row_rdata[s].valid && (row_rdata[s].kind == r_word.kind);
                end
                n_state = S_POP;
            end
            S_POP: begin
                res.match_count = (32'(pop) > 15) ? 4'd15 : 4'(pop);
                fin             = 1'b1;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        // Deliver straight into the output register when it is free.
        if (fin) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out_word  = res;
                n_state     = S_IDLE;
            end else begin
                n_res   = res;
                n_state = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word     <= n_word;
        r_mb       <= n_mb;
        r_mod_row  <= n_mod_row;
        r_fwd      <= n_fwd;
        r_match    <= n_match;
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // Real commands always close input; a no-op only when the output is busy.
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_word.command != CMD_NOP) |=> !o_in_ready)
        else $error("input accepted twice back to back");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status != ST_OK) |->
            (o_out_word.slot_index == 3'd0 && o_out_word.match_count == 4'd0))
        else $error("failed command reports slot or count");

    a_quiet_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_CNT || r_state == S_POP ||
         r_state == S_DONE) |-> (!row_we && !mb_we))
        else $error("RAM write outside an update state");

    a_fwd_same_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NEW && r_fwd) |-> (r_word.bucket_id == r_mb.bucket_id))
        else $error("forwarded row belongs to another bucket");

endmodule

// File: hdl/bsmt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsmt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bsmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the slot membership table core word by word against a predictor
// kept in step with every accepted command. A short table of directed words
// hits the corner cases. Random words follow, drawn mostly from small pools of
// members, rooms and kinds so that rooms fill up and counts climb. Both
// handshakes are throttled at random.
// ----------------------------------------------------------------------------
module testbench;
    import bsmt_pkg::*;

    localparam int RANDOM_WORDS = 800;
    localparam int CYCLE_LIMIT  = 400000;   // clearing pass plus worst-case stalls, many times over
    localparam int DRAIN_CYCLES = 8;        // extra wait after the last expected result
    localparam bit TYPED        = 1'b1;     // table row carries its own expected word
    localparam bit PREDICTED    = 1'b0;     // table row is checked against the predictor

    // Receiver throttle styles.
    typedef enum int {RX_STREAM, RX_COIN, RX_PATTERN, RX_TRICKLE} t_rx_mode;

    typedef struct {
        t_in_word  word;
        bit        typed;
        t_out_word want;
    } t_row_case;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_word;

    // Predictor copy of the table: one seat per (room, slot), one entry per member.
    bit          seat_used   [BUCKETS*SLOTS];
    bit  [9:0]   seat_member [BUCKETS*SLOTS];
    bit  [15:0]  seat_kind   [BUCKETS*SLOTS];
    bit          member_placed [MEMBERS];
    bit  [7:0]   member_room   [MEMBERS];

    t_out_word   pending_results[$];   // expected result words, oldest first
    t_row_case   directed_rows[$];
    t_out_word   got_word;
    t_out_word   want_word;

    int          mismatches  = 0;
    int          cycle_count = 0;
    int          burst_left  = 0;
    bit          steady_send = 1'b0;

    t_rx_mode    rx_mode  = RX_STREAM;
    int          rx_timer = 0;
    logic [7:0]  rx_mask  = 8'hff;

    // Random pools, small so that rooms fill and kinds repeat.
    int unsigned member_pool [28];
    int unsigned room_pool   [3];
    int unsigned kind_pool   [3];

    bucketed_slot_membership_table_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Frees the member's seat, if it holds one, and marks it unplaced.
    function automatic bit vacate(input int m);
        int  base;
        bit  freed;
        if (!member_placed[m])
            return 1'b0;
        base  = member_room[m] * SLOTS;
        freed = 1'b0;
        if (member_room[m] < BUCKETS) begin
            for (int s = 0; s < SLOTS; s++) begin
                if (!freed && seat_used[base+s] && seat_member[base+s] == m) begin
                    seat_used[base+s] = 1'b0;
                    freed = 1'b1;
                end
            end
        end
        member_placed[m] = 1'b0;
        return 1'b1;
    endfunction

    // Applies one command word to the predictor and returns its result word.
    function automatic t_out_word apply_command(input t_in_word w);
        t_out_word res;
        int        m;
        int        r;
        int        base;
        int        hits;
        bit        seated;
        res = '0;
        m   = w.member_id;
        r   = w.bucket_id;
        if (w.command == CMD_NOP)
            return res;
        if (m >= MEMBERS) begin
            res.status = ST_UNPLACED;
            return res;
        end
        case (w.command)
            CMD_PLACE: begin
                // old seat goes first, even when the target room is the same
                void'(vacate(m));
                res.status = ST_FULL;
                seated     = 1'b0;
                if (r < BUCKETS) begin
                    base = r * SLOTS;
                    for (int s = 0; s < SLOTS; s++) begin
                        if (!seated && !seat_used[base+s]) begin
                            seat_used[base+s]   = 1'b1;
                            seat_member[base+s] = w.member_id;
                            seat_kind[base+s]   = w.kind;
                            member_placed[m]    = 1'b1;
                            member_room[m]      = w.bucket_id;
                            res.status          = ST_OK;
                            res.slot_index      = s[2:0];
                            seated              = 1'b1;
                        end
                    end
                end
            end
            CMD_REMOVE: begin
                res.status = vacate(m) ? ST_OK : ST_UNPLACED;
            end
            CMD_COUNT: begin
                if (!member_placed[m]) begin
                    res.status = ST_UNPLACED;
                end else begin
                    hits = 0;
                    base = member_room[m] * SLOTS;
                    if (member_room[m] < BUCKETS) begin
                        for (int s = 0; s < SLOTS; s++)
                            if (seat_used[base+s] && seat_kind[base+s] == w.kind)
                                hits++;
                    end
                    res.match_count = (hits > 15) ? 4'd15 : hits[3:0];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------

    task automatic table_row(input logic [1:0] cmd, input int m, input int r, input int k,
                             input bit typed, input logic [1:0] st, input int slot,
                             input int cnt);
        t_row_case c;
        c.word  = '{command: cmd, member_id: m[9:0], bucket_id: r[7:0], kind: k[15:0]};
        c.typed = typed;
        c.want  = '{status: st, slot_index: slot[2:0], match_count: cnt[3:0]};
        directed_rows.push_back(c);
    endtask

    // Offers one word, holding it until accepted; bursts and gaps set the pace.
    // The predictor runs at the accepting edge so expectations stay in order.
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word typed_want);
        int        gap;
        t_out_word predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (steady_send || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predicted = apply_command(w);
        pending_results.push_back(typed ? typed_want : predicted);
    endtask

    // ------------------------------------------------------------------------
    // Result side: throttle and checker
    // ------------------------------------------------------------------------

    // Throttle style changes at random intervals; one style never stalls.
    always @(posedge i_clk) begin
        if (rx_timer == 0) begin
            rx_mode  <= t_rx_mode'($urandom_range(0, 3));
            rx_timer <= $urandom_range(32, 160);
            rx_mask  <= 8'($urandom) | 8'h01;
        end else begin
            rx_timer <= rx_timer - 1;
        end
        case (rx_mode)
            RX_STREAM:  i_out_ready <= 1'b1;
            RX_COIN:    i_out_ready <= 1'($urandom_range(0, 1));
            RX_PATTERN: i_out_ready <= rx_mask[cycle_count[2:0]];
            default:    i_out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Every accepted result word is matched with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            got_word = o_out_word;
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: status %0d slot %0d count %0d",
                       got_word.status, got_word.slot_index, got_word.match_count);
                mismatches++;
            end else begin
                want_word = pending_results.pop_front();
                if (got_word.status !== want_word.status) begin
                    $error("status: expected %0d, got %0d", want_word.status, got_word.status);
                    mismatches++;
                end
                if (got_word.slot_index !== want_word.slot_index) begin
                    $error("slot_index: expected %0d, got %0d",
                           want_word.slot_index, got_word.slot_index);
                    mismatches++;
                end
                if (got_word.match_count !== want_word.match_count) begin
                    $error("match_count: expected %0d, got %0d",
                           want_word.match_count, got_word.match_count);
                    mismatches++;
                end
            end
        end
    end

    // Hard stop in case the core hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_in_word w;
        int       pick;

        // Directed words. Starts from an empty table.
        table_row(CMD_REMOVE, 0,    0,   16'h0000, TYPED, ST_UNPLACED, 0, 0); // remove unplaced
        table_row(CMD_COUNT,  1023, 0,   16'hffff, TYPED, ST_UNPLACED, 0, 0); // count unplaced
        table_row(CMD_NOP,    1023, 255, 16'hffff, TYPED, ST_OK,       0, 0); // no-op, all ones
        table_row(CMD_PLACE,  1023, 255, 16'hffff, TYPED, ST_OK,       0, 0);
        // fill room 0 with one kind
        for (int i = 0; i < SLOTS; i++)
            table_row(CMD_PLACE, i, 0, 16'h1234, TYPED, ST_OK, i, 0);
        table_row(CMD_PLACE,  8,    0,   16'h0000, TYPED, ST_FULL,     0, 0); // room full
        table_row(CMD_COUNT,  8,    0,   16'h0000, TYPED, ST_UNPLACED, 0, 0); // left unplaced
        table_row(CMD_COUNT,  0,    0,   16'h1234, TYPED, ST_OK,       0, 8); // full-room count
        table_row(CMD_REMOVE, 3,    0,   16'h0000, TYPED, ST_OK,       0, 0);
        table_row(CMD_REMOVE, 3,    0,   16'h0000, TYPED, ST_UNPLACED, 0, 0);
        // re-place into the room already held: lands in the freed lower slot
        table_row(CMD_PLACE,  5,    0,   16'h0000, PREDICTED, ST_OK, 0, 0);
        table_row(CMD_PLACE,  8,    0,   16'h0000, PREDICTED, ST_OK, 0, 0);
        table_row(CMD_COUNT,  2,    0,   16'h0000, PREDICTED, ST_OK, 0, 0);
        // move into a full room: old seat is lost anyway
        table_row(CMD_PLACE,  1023, 0,   16'hffff, PREDICTED, ST_OK, 0, 0);
        table_row(CMD_COUNT,  1023, 0,   16'hffff, PREDICTED, ST_OK, 0, 0);
        table_row(CMD_PLACE,  0,    0,   16'h0000, PREDICTED, ST_OK, 0, 0);
        table_row(CMD_COUNT,  7,    0,   16'h1234, PREDICTED, ST_OK, 0, 0);
        table_row(CMD_NOP,    0,    0,   16'h0000, TYPED, ST_OK,       0, 0); // no-op, all zeros

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Core sits in its clearing pass first; send_word just waits on ready.
        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

        // Random words: mostly pool traffic so rooms fill, counts rise, moves
        // collide; the rest is fully random to toggle every field bit.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 200 == 0) begin
                foreach (member_pool[i]) member_pool[i] = $urandom_range(0, MEMBERS - 1);
                foreach (room_pool[i])   room_pool[i]   = $urandom_range(0, BUCKETS - 1);
                foreach (kind_pool[i])   kind_pool[i]   = $urandom_range(0, 16'hffff);
            end
            steady_send = (n >= 300 && n < 380);
            pick = $urandom_range(0, 99);
            if (pick < 45)      w.command = CMD_PLACE;
            else if (pick < 65) w.command = CMD_REMOVE;
            else if (pick < 95) w.command = CMD_COUNT;
            else                w.command = CMD_NOP;
            if ($urandom_range(0, 99) < 85) begin
                w.member_id = 10'(member_pool[$urandom_range(0, 27)]);
                w.bucket_id = 8'(room_pool[$urandom_range(0, 2)]);
                w.kind      = 16'(kind_pool[$urandom_range(0, 2)]);
            end else begin
                w.member_id = 10'($urandom);
                w.bucket_id = 8'($urandom);
                w.kind      = 16'($urandom);
            end
            send_word(w, PREDICTED, '0);
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
